[src/cvfm_pkg.sv]
// shared types and constants for the current/voltage fault monitor
// no dependencies; used by every module under src
package cvfm_pkg;

   localparam int DEF_BLOCK_LEN   = 10;
   localparam int DEF_SAMPLE_BITS = 12;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ALPHA_W    = 16;
   localparam int LIMIT_W    = 12;
   localparam int TRIP_W     = 16;
   localparam int ERR_W      = 2;
   localparam int TRIPPED_W  = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_LIMIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_VOLT_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_VOLT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_TRIP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_VOLT_TRIP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_VOLT_TRIP   = 3'd6;

   // reset values of the registers
   localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA     = 16'd7314;
   localparam logic [LIMIT_W-1:0] RST_CURRENT_LIMIT    = 12'd4095;
   localparam logic [LIMIT_W-1:0] RST_OVER_VOLT_LIMIT  = 12'd4095;
   localparam logic [LIMIT_W-1:0] RST_UNDER_VOLT_LIMIT = 12'd0;
   localparam logic [TRIP_W-1:0]  RST_TRIP_COUNT       = 16'd100;

   // latched fault codes
   localparam logic [ERR_W-1:0] ERR_NONE          = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVER_CURRENT  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVER_VOLTAGE  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_UNDER_VOLTAGE = 2'd3;

   typedef struct packed {
      logic [ALPHA_W-1:0] filter_alpha;
      logic [LIMIT_W-1:0] current_limit;
      logic [TRIP_W-1:0]  current_trip;
      logic [TRIP_W-1:0]  over_volt_trip;
      logic [TRIP_W-1:0]  under_volt_trip;
   } cfg_type;

endpackage

[src/cvfm_lowpass.sv]
// first-order low-pass step: prev + ((alpha * (sample - prev)) >>> 16)
// depends on cvfm_pkg
module cvfm_lowpass #(
   parameter int SAMPLE_BITS = cvfm_pkg::DEF_SAMPLE_BITS
) (
   input  logic [SAMPLE_BITS-1:0]      sample,
   input  logic [SAMPLE_BITS-1:0]      prev,
   input  logic [cvfm_pkg::ALPHA_W-1:0] alpha,
   output logic [SAMPLE_BITS-1:0]      next_value
);

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int PROD_W = DIFF_W + cvfm_pkg::ALPHA_W + 1;

   logic signed [DIFF_W-1:0]             diff;
   logic signed [cvfm_pkg::ALPHA_W:0]    alpha_s;
   logic signed [PROD_W-1:0]             prod;
   logic signed [PROD_W-1:0]             step;

   assign diff    = $signed({1'b0, sample}) - $signed({1'b0, prev});
   assign alpha_s = $signed({1'b0, alpha});
   assign prod    = PROD_W'(alpha_s) * PROD_W'(diff);
   // arithmetic shift floors negative steps
   assign step    = prod >>> cvfm_pkg::ALPHA_W;
   // result always lies between prev and sample, so truncation is exact
   assign next_value = prev + step[SAMPLE_BITS-1:0];

endmodule

[src/cvfm_leaky.sv]
// saturating leaky fault counter: on each enabled step, up on hit, down by one toward zero otherwise
// depends on cvfm_pkg
module cvfm_leaky (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic                        hit,
   input  logic [cvfm_pkg::TRIP_W-1:0] trip_count,
   output logic                        tripped
);

   logic [cvfm_pkg::TRIP_W-1:0] count_ff;
   logic [cvfm_pkg::TRIP_W-1:0] count_in;
   logic                        at_ceiling;

   // count + 1 > trip is the same as count >= trip, with no wrap
   assign at_ceiling = (count_ff >= trip_count);
   assign tripped    = step_en & hit & at_ceiling;

   always_comb begin
      count_in = count_ff;
      if (step_en) begin
         if (hit) begin
            count_in = at_ceiling ? trip_count : count_ff + 1'b1;
         end else if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

[src/cvfm_csr.sv]
// configuration registers and the block-sum thresholds derived from them
// depends on cvfm_pkg
module cvfm_csr #(
   parameter int BLOCK_LEN = cvfm_pkg::DEF_BLOCK_LEN,
   parameter int THR_W     = cvfm_pkg::LIMIT_W + 1 + $clog2(BLOCK_LEN + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [cvfm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cvfm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output cvfm_pkg::cfg_type              cfg,
   output logic [THR_W-1:0]               over_thr,
   output logic [THR_W-1:0]               under_thr
);

   cvfm_pkg::cfg_type               cfg_ff;
   cvfm_pkg::cfg_type               cfg_in;
   logic [cvfm_pkg::LIMIT_W-1:0]    ov_limit_ff;
   logic [cvfm_pkg::LIMIT_W-1:0]    ov_limit_in;
   logic [cvfm_pkg::LIMIT_W-1:0]    uv_limit_ff;
   logic [cvfm_pkg::LIMIT_W-1:0]    uv_limit_in;
   logic [THR_W-1:0]                over_thr_ff;
   logic [THR_W-1:0]                over_thr_in;
   logic [THR_W-1:0]                under_thr_ff;
   logic [THR_W-1:0]                under_thr_in;

   always_comb begin
      cfg_in      = cfg_ff;
      ov_limit_in = ov_limit_ff;
      uv_limit_in = uv_limit_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            cvfm_pkg::CSR_FILTER_ALPHA:
               cfg_in.filter_alpha = csr_wdata[cvfm_pkg::ALPHA_W-1:0];
            cvfm_pkg::CSR_CURRENT_LIMIT:
               cfg_in.current_limit = csr_wdata[cvfm_pkg::LIMIT_W-1:0];
            cvfm_pkg::CSR_OVER_VOLT_LIMIT:
               ov_limit_in = csr_wdata[cvfm_pkg::LIMIT_W-1:0];
            cvfm_pkg::CSR_UNDER_VOLT_LIMIT:
               uv_limit_in = csr_wdata[cvfm_pkg::LIMIT_W-1:0];
            cvfm_pkg::CSR_CURRENT_TRIP:
               cfg_in.current_trip = csr_wdata[cvfm_pkg::TRIP_W-1:0];
            cvfm_pkg::CSR_OVER_VOLT_TRIP:
               cfg_in.over_volt_trip = csr_wdata[cvfm_pkg::TRIP_W-1:0];
            cvfm_pkg::CSR_UNDER_VOLT_TRIP:
               cfg_in.under_volt_trip = csr_wdata[cvfm_pkg::TRIP_W-1:0];
            default: ;
         endcase
      end
   end

   // floor(sum/N) > L  <=>  sum >= (L+1)*N ;  floor(sum/N) < U  <=>  sum < U*N
   assign over_thr_in  = THR_W'({1'b0, ov_limit_ff} + (cvfm_pkg::LIMIT_W + 1)'(1))
                         * THR_W'(BLOCK_LEN);
   assign under_thr_in = THR_W'(uv_limit_ff) * THR_W'(BLOCK_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha    <= cvfm_pkg::RST_FILTER_ALPHA;
         cfg_ff.current_limit   <= cvfm_pkg::RST_CURRENT_LIMIT;
         cfg_ff.current_trip    <= cvfm_pkg::RST_TRIP_COUNT;
         cfg_ff.over_volt_trip  <= cvfm_pkg::RST_TRIP_COUNT;
         cfg_ff.under_volt_trip <= cvfm_pkg::RST_TRIP_COUNT;
         ov_limit_ff            <= cvfm_pkg::RST_OVER_VOLT_LIMIT;
         uv_limit_ff            <= cvfm_pkg::RST_UNDER_VOLT_LIMIT;
      end else begin
         cfg_ff      <= cfg_in;
         ov_limit_ff <= ov_limit_in;
         uv_limit_ff <= uv_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      over_thr_ff  <= over_thr_in;
      under_thr_ff <= under_thr_in;
   end

   assign cfg       = cfg_ff;
   assign over_thr  = over_thr_ff;
   assign under_thr = under_thr_ff;

endmodule

[src/current_voltage_fault_monitor.sv]
// Current and supply-voltage fault monitor with leaky-bucket fault filtering.
// Request channel (req_*): one beat carries a current and a voltage sample.
// Response channel (rsp_*): one beat per request beat, in order, carrying the
// latched error code, the per-tick trip flags and both filtered levels.
// A beat moves when valid is high and stall is low.
// Pipeline: input register, filter stage, current check and voltage block
// accumulate, voltage checks and output register. One beat per cycle is
// sustained while rsp_stall stays low, set by the filter stage, whose state
// feeds back into its own register.
// Each pipeline register loads whenever its downstream slot is empty or
// moving, so bubbles close up and requests keep being taken while one
// response waits; with rsp_stall held high the pipeline fills and then
// req_stall goes high. Held responses do not change.
// Configuration (csr_*): plain write port, write only while no beat is in
// flight. Reset (synchronous) restores register defaults, clears filters,
// block sum, counters and the latched error, and empties the pipeline.
// depends on cvfm_pkg, cvfm_csr, cvfm_lowpass, cvfm_leaky
module current_voltage_fault_monitor #(
   parameter int BLOCK_LEN   = cvfm_pkg::DEF_BLOCK_LEN,
   parameter int SAMPLE_BITS = cvfm_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [cvfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cvfm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_current_sample,
   input  logic [SAMPLE_BITS-1:0]            req_voltage_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cvfm_pkg::ERR_W-1:0]        rsp_error_code,
   output logic [cvfm_pkg::TRIPPED_W-1:0]    rsp_tripped_now,
   output logic [SAMPLE_BITS-1:0]            rsp_current_level,
   output logic [SAMPLE_BITS-1:0]            rsp_voltage_level
);

   localparam int IDX_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_LEN + 1);
   localparam int THR_W = cvfm_pkg::LIMIT_W + 1 + $clog2(BLOCK_LEN + 1);
   localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
   localparam int CUR_W = (SAMPLE_BITS > cvfm_pkg::LIMIT_W) ? SAMPLE_BITS
                                                            : cvfm_pkg::LIMIT_W;

   cvfm_pkg::cfg_type       cfg;
   logic [THR_W-1:0]        over_thr;
   logic [THR_W-1:0]        under_thr;

   // handshake chain
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   logic ready0, ready1, ready2, ready3;
   logic load0, load1, load2, load3;

   // stage 0: input register
   logic [SAMPLE_BITS-1:0]  cur_smp_ff, cur_smp_in;
   logic [SAMPLE_BITS-1:0]  volt_smp_ff, volt_smp_in;

   // stage 1: filter state
   logic [SAMPLE_BITS-1:0]  cur_filt_ff, cur_filt_in;
   logic [SAMPLE_BITS-1:0]  volt_filt_ff, volt_filt_in;
   logic [SAMPLE_BITS-1:0]  cur_filt_next;
   logic [SAMPLE_BITS-1:0]  volt_filt_next;

   // stage 2: current check and block accumulate
   logic [SUM_W-1:0]        blk_sum_ff, blk_sum_in;
   logic [IDX_W-1:0]        blk_idx_ff, blk_idx_in;
   logic                    blk_done_ff, blk_done_in;
   logic [SUM_W-1:0]        mean_sum_ff, mean_sum_in;
   logic                    cur_trip_ff, cur_trip_in;
   logic [SAMPLE_BITS-1:0]  cur_lvl_ff, cur_lvl_in;
   logic [SAMPLE_BITS-1:0]  volt_lvl_ff, volt_lvl_in;
   logic [SUM_W-1:0]        sum_add;
   logic                    blk_last;
   logic                    cur_hit;
   logic                    cur_trip;

   // stage 3: voltage checks and output register
   logic [cvfm_pkg::ERR_W-1:0]     err_ff, err_in;
   logic [cvfm_pkg::TRIPPED_W-1:0] tripped_ff, tripped_in;
   logic [SAMPLE_BITS-1:0]         out_cur_ff, out_cur_in;
   logic [SAMPLE_BITS-1:0]         out_volt_ff, out_volt_in;
   logic                           ov_hit, uv_hit;
   logic                           ov_trip, uv_trip;
   logic                           volt_step;

   cvfm_csr #(
      .BLOCK_LEN (BLOCK_LEN),
      .THR_W     (THR_W)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .over_thr     (over_thr),
      .under_thr    (under_thr)
   );

   // a slot loads when it is empty or its beat moves on
   assign ready3 = !v3_ff | !rsp_stall;
   assign ready2 = !v2_ff | ready3;
   assign ready1 = !v1_ff | ready2;
   assign ready0 = !v0_ff | ready1;
   assign load0  = req_valid & ready0;
   assign load1  = v0_ff & ready1;
   assign load2  = v1_ff & ready2;
   assign load3  = v2_ff & ready3;

   assign v0_in = ready0 ? req_valid : v0_ff;
   assign v1_in = ready1 ? v0_ff : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;

   // stage 0
   assign cur_smp_in  = load0 ? req_current_sample : cur_smp_ff;
   assign volt_smp_in = load0 ? req_voltage_sample : volt_smp_ff;

   // stage 1
   cvfm_lowpass #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_cur_lp (
      .sample     (cur_smp_ff),
      .prev       (cur_filt_ff),
      .alpha      (cfg.filter_alpha),
      .next_value (cur_filt_next)
   );

   cvfm_lowpass #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_volt_lp (
      .sample     (volt_smp_ff),
      .prev       (volt_filt_ff),
      .alpha      (cfg.filter_alpha),
      .next_value (volt_filt_next)
   );

   assign cur_filt_in  = load1 ? cur_filt_next : cur_filt_ff;
   assign volt_filt_in = load1 ? volt_filt_next : volt_filt_ff;

   // stage 2
   assign cur_hit = CUR_W'(cur_filt_ff) > CUR_W'(cfg.current_limit);

   cvfm_leaky u_cur_cnt (
      .clock      (clock),
      .reset      (reset),
      .step_en    (load2),
      .hit        (cur_hit),
      .trip_count (cfg.current_trip),
      .tripped    (cur_trip)
   );

   assign sum_add  = blk_sum_ff + SUM_W'(volt_filt_ff);
   assign blk_last = (blk_idx_ff == IDX_W'(BLOCK_LEN - 1));

   always_comb begin
      blk_sum_in  = blk_sum_ff;
      blk_idx_in  = blk_idx_ff;
      blk_done_in = blk_done_ff;
      mean_sum_in = mean_sum_ff;
      cur_trip_in = cur_trip_ff;
      cur_lvl_in  = cur_lvl_ff;
      volt_lvl_in = volt_lvl_ff;
      if (load2) begin
         cur_trip_in = cur_trip;
         cur_lvl_in  = cur_filt_ff;
         volt_lvl_in = volt_filt_ff;
         blk_done_in = blk_last;
         if (blk_last) begin
            // block complete: hand the sum on and restart
            mean_sum_in = sum_add;
            blk_sum_in  = '0;
            blk_idx_in  = '0;
         end else begin
            blk_sum_in  = sum_add;
            blk_idx_in  = blk_idx_ff + 1'b1;
         end
      end
   end

   // stage 3
   assign volt_step = load3 & blk_done_ff;
   assign ov_hit    = CMP_W'(mean_sum_ff) >= CMP_W'(over_thr);
   assign uv_hit    = CMP_W'(mean_sum_ff) < CMP_W'(under_thr);

   cvfm_leaky u_ov_cnt (
      .clock      (clock),
      .reset      (reset),
      .step_en    (volt_step),
      .hit        (ov_hit),
      .trip_count (cfg.over_volt_trip),
      .tripped    (ov_trip)
   );

   cvfm_leaky u_uv_cnt (
      .clock      (clock),
      .reset      (reset),
      .step_en    (volt_step),
      .hit        (uv_hit),
      .trip_count (cfg.under_volt_trip),
      .tripped    (uv_trip)
   );

   always_comb begin
      err_in      = err_ff;
      tripped_in  = tripped_ff;
      out_cur_in  = out_cur_ff;
      out_volt_in = out_volt_ff;
      if (load3) begin
         tripped_in  = {uv_trip, ov_trip, cur_trip_ff};
         out_cur_in  = cur_lvl_ff;
         out_volt_in = volt_lvl_ff;
         // later checks in the tick win
         if (uv_trip) begin
            err_in = cvfm_pkg::ERR_UNDER_VOLTAGE;
         end else if (ov_trip) begin
            err_in = cvfm_pkg::ERR_OVER_VOLTAGE;
         end else if (cur_trip_ff) begin
            err_in = cvfm_pkg::ERR_OVER_CURRENT;
         end
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         cur_filt_ff  <= '0;
         volt_filt_ff <= '0;
         blk_sum_ff   <= '0;
         blk_idx_ff   <= '0;
         blk_done_ff  <= 1'b0;
         err_ff       <= cvfm_pkg::ERR_NONE;
      end else begin
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         cur_filt_ff  <= cur_filt_in;
         volt_filt_ff <= volt_filt_in;
         blk_sum_ff   <= blk_sum_in;
         blk_idx_ff   <= blk_idx_in;
         blk_done_ff  <= blk_done_in;
         err_ff       <= err_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_smp_ff  <= cur_smp_in;
      volt_smp_ff <= volt_smp_in;
      mean_sum_ff <= mean_sum_in;
      cur_trip_ff <= cur_trip_in;
      cur_lvl_ff  <= cur_lvl_in;
      volt_lvl_ff <= volt_lvl_in;
      tripped_ff  <= tripped_in;
      out_cur_ff  <= out_cur_in;
      out_volt_ff <= out_volt_in;
   end

   assign req_stall         = !ready0;
   assign rsp_valid         = v3_ff;
   assign rsp_error_code    = err_ff;
   assign rsp_tripped_now   = tripped_ff;
   assign rsp_current_level = out_cur_ff;
   assign rsp_voltage_level = out_volt_ff;

endmodule
